[design/bss_pkg.sv]
// bss_pkg: shared constants, codes and types for the byte stack with search.
// Used by bss_mem, bss_ctrl and byte_stack_with_search. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    // default number of stack entries
    localparam int DEPTH_DEF = 64;

    // field widths fixed by the item format
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [CAP_W-1:0]   CAP_RESET     = 7'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SCAN,
        ST_DONE
    } state_t;

    // one finished result, controller to output register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   found_index;
        logic [VALUE_W-1:0]  top_value;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } result_t;

endpackage

`default_nettype wire

[design/bss_mem.sv]
// bss_mem: entry RAM, one write port and one read port, registered read data.
// Depends on bss_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module bss_mem #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [bss_pkg::VALUE_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [bss_pkg::VALUE_W-1:0] rdata
);

    logic [bss_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [bss_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/bss_ctrl.sv]
// bss_ctrl: stack count, cached top byte and the sequencer that drives the
// entry RAM (push write, pop top refill, search walk). Depends on bss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bss_pkg::CAP_W-1:0]   capacity,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bss_pkg::OP_W-1:0]    in_op,
    input  wire logic [bss_pkg::VALUE_W-1:0] in_value,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_waddr,
    output logic      [bss_pkg::VALUE_W-1:0] mem_wdata,
    output logic                             mem_re,
    output logic      [AW-1:0]               mem_raddr,
    input  wire logic [bss_pkg::VALUE_W-1:0] mem_rdata,
    output logic                             res_valid,
    output bss_pkg::result_t                 res,
    input  wire logic                        res_take
);

    localparam int CMPW = (CW > bss_pkg::CAP_W) ? CW : bss_pkg::CAP_W;

    bss_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [bss_pkg::VALUE_W-1:0]      top_reg, top_next;
    logic [bss_pkg::VALUE_W-1:0]      val_reg, val_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [bss_pkg::STATUS_W-1:0]     stat_reg, stat_next;
    logic [bss_pkg::FIDX_W-1:0]       fidx_reg, fidx_next;

    logic accept;
    logic full;
    logic hit;
    logic last;

    assign accept = in_valid && in_ready;
    // full against the written capacity and the physical depth
    assign full = (CMPW'(cnt_reg) >= CMPW'(capacity)) || (cnt_reg == CW'(DEPTH));
    assign hit  = (mem_rdata == val_reg);
    assign last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bss_pkg::ST_DONE;
                    if (in_op == bss_pkg::OP_POP && cnt_reg > CW'(1))
                    begin
                        state_next = bss_pkg::ST_POP_RD;
                    end
                    else if (in_op == bss_pkg::OP_SEARCH && cnt_reg != '0)
                    begin
                        state_next = bss_pkg::ST_SCAN;
                    end
                end
            end
            bss_pkg::ST_POP_RD:
            begin
                state_next = bss_pkg::ST_DONE;
            end
            bss_pkg::ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = bss_pkg::ST_DONE;
                end
            end
            bss_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = bss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bss_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        val_next  = val_reg;
        idx_next  = idx_reg;
        stat_next = stat_reg;
        fidx_next = fidx_reg;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = AW'(cnt_reg);
        mem_wdata = in_value;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    val_next  = in_value;
                    fidx_next = '0;
                    idx_next  = '0;
                    stat_next = bss_pkg::STAT_OK;
                    case (in_op)
                        bss_pkg::OP_PUSH:
                        begin
                            if (full)
                            begin
                                stat_next = bss_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                top_next = in_value;
                            end
                        end
                        bss_pkg::OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = bss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                                // refill the cached top from the entry below
                                if (cnt_reg > CW'(1))
                                begin
                                    mem_re    = 1'b1;
                                    mem_raddr = AW'(cnt_reg - CW'(2));
                                end
                            end
                        end
                        bss_pkg::OP_SEARCH:
                        begin
                            stat_next = bss_pkg::STAT_NOT_FOUND;
                            if (cnt_reg != '0)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end
                        end
                        default:
                        begin
                            stat_next = bss_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            bss_pkg::ST_POP_RD:
            begin
                top_next = mem_rdata;
            end
            bss_pkg::ST_SCAN:
            begin
                // rdata holds entry idx_reg
                if (hit)
                begin
                    stat_next = bss_pkg::STAT_OK;
                    fidx_next = bss_pkg::FIDX_W'(idx_reg);
                end
                else if (!last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            bss_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.status      = stat_reg;
        res.found_index = fidx_reg;
        res.top_value   = (cnt_reg != '0) ? top_reg : '0;
        res.count       = bss_pkg::COUNT_W'(cnt_reg);
        res.is_empty    = (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bss_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        stat_reg <= stat_next;
        fidx_reg <= fidx_next;
    end

    // count never passes the physical depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("stack count above depth");

    // every accepted item leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != bss_pkg::ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

    // search walk only over a non-empty stack, and within the count
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bss_pkg::ST_SCAN |-> (cnt_reg != '0 && CW'(idx_reg) < cnt_reg))
        else $error("search index outside stored entries");

    // top refill follows a pop that left entries behind
    a_pop_refill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bss_pkg::ST_POP_RD |->
            (cnt_reg != '0 && $past(in_op) == bss_pkg::OP_POP))
        else $error("top refill without a pop");

    // a taken result returns the sequencer to idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> state_reg == bss_pkg::ST_IDLE)
        else $error("result taken but sequencer not idle");

endmodule

`default_nettype wire

[design/byte_stack_with_search.sv]
// Sequence: push, pop to empty, failed ops and code 3 go from accept straight to ST_DONE;
//   a pop that leaves entries passes through ST_POP_RD (one entry RAM read refills the top byte);
//   a search walks ST_SCAN over k entries, k = entries probed (1..count), one RAM read per cycle.
// Flow: one item at a time; the sequencer accepts no new item until its result is handed
//   to the output register; one result may wait in the output register, a second one
//   holds the sequencer and stalls the input until the first is taken.
// Reset: count 0, capacity 64, no result pending; entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

// byte_stack_with_search: top level; APB capacity register, output register,
// bss_ctrl sequencer and bss_mem entry RAM. Depends on bss_pkg.
module byte_stack_with_search #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bss_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bss_pkg::PDATA_W-1:0]    pwdata,
    output logic      [bss_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,

    // request items
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [bss_pkg::OP_W-1:0]       operation,
    input  wire logic [bss_pkg::VALUE_W-1:0]    value,

    // result items
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic      [bss_pkg::STATUS_W-1:0]   status,
    output logic      [bss_pkg::FIDX_W-1:0]     found_index,
    output logic      [bss_pkg::VALUE_W-1:0]    top_value,
    output logic      [bss_pkg::COUNT_W-1:0]    count,
    output logic                                is_empty
);

    localparam int AW = $clog2(DEPTH);

    // ---------------------------------------------------------------
    // Capacity register. Word decode: byte offsets within word 0 all
    // hit the capacity register; the upper word is unmapped.
    // ---------------------------------------------------------------
    logic [bss_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic                      cap_sel;
    logic                      cfg_wr;

    assign cap_sel = (paddr[bss_pkg::PADDR_W-1:2] ==
                      bss_pkg::ADDR_CAPACITY[bss_pkg::PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? bss_pkg::PDATA_W'(capacity_reg) : '0;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_wr && cap_sel)
        begin
            capacity_next = pwdata[bss_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bss_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and entry RAM
    // ---------------------------------------------------------------
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [bss_pkg::VALUE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [bss_pkg::VALUE_W-1:0] mem_rdata;
    logic                        res_valid;
    logic                        res_take;
    bss_pkg::result_t            res;

    bss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .in_op     (operation),
        .in_value  (value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    bss_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Output register: the sequencer hands over a finished item when
    // the register is free or being drained in the same cycle.
    // ---------------------------------------------------------------
    logic             out_valid_reg, out_valid_next;
    bss_pkg::result_t out_res_reg, out_res_next;

    assign res_take = res_valid && (!out_valid_reg || result_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_res_reg.status;
    assign found_index  = out_res_reg.found_index;
    assign top_value    = out_res_reg.top_value;
    assign count        = out_res_reg.count;
    assign is_empty     = out_res_reg.is_empty;

endmodule

`default_nettype wire

[tb/stack_result_checker.sv]
// stack_result_checker: watches the config, request and result channels of
// byte_stack_with_search, predicts each result and compares it. Depends on bss_pkg.
`timescale 1ns / 1ps

module stack_result_checker #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [bss_pkg::PADDR_W-1:0]   paddr,
    input  logic [bss_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  logic [bss_pkg::OP_W-1:0]      operation,
    input  logic [bss_pkg::VALUE_W-1:0]   value,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [bss_pkg::STATUS_W-1:0]  status,
    input  logic [bss_pkg::FIDX_W-1:0]    found_index,
    input  logic [bss_pkg::VALUE_W-1:0]   top_value,
    input  logic [bss_pkg::COUNT_W-1:0]   count,
    input  logic                          is_empty,
    output int                            errors,
    output int                            pending
);

    logic [bss_pkg::VALUE_W-1:0] stack_mem [DEPTH];
    int                          fill;
    logic [bss_pkg::CAP_W-1:0]   cap_reg;
    bss_pkg::result_t            expected_results [$];
    bss_pkg::result_t            want;

    // Applies one operation to the shadow stack, returns the result it yields.
    function automatic bss_pkg::result_t apply_op(logic [bss_pkg::OP_W-1:0] op,
                                                  logic [bss_pkg::VALUE_W-1:0] byte_in);
        bss_pkg::result_t r;
        int               lim;
        lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        r = '0;
        r.status = bss_pkg::STAT_OK;
        case (op)
            bss_pkg::OP_PUSH:
                if (fill >= lim)
                    r.status = bss_pkg::STAT_FULL;
                else
                begin
                    stack_mem[fill] = byte_in;
                    fill++;
                end
            bss_pkg::OP_POP:
                if (fill == 0)
                    r.status = bss_pkg::STAT_EMPTY;
                else
                    fill--;
            bss_pkg::OP_SEARCH:
            begin
                // walk downward so the lowest match is the one kept
                r.status = bss_pkg::STAT_NOT_FOUND;
                for (int i = fill - 1; i >= 0; i--)
                begin
                    if (stack_mem[i] == byte_in)
                    begin
                        r.status      = bss_pkg::STAT_OK;
                        r.found_index = i[bss_pkg::FIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.count     = fill[bss_pkg::COUNT_W-1:0];
        r.is_empty  = (fill == 0);
        r.top_value = (fill > 0) ? stack_mem[fill-1] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill    = 0;
            cap_reg = bss_pkg::CAP_RESET;
            expected_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d count %0d",
                           status, count);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (found_index !== want.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, found_index);
                        errors++;
                    end
                    if (top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d", want.top_value, top_value);
                        errors++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        errors++;
                    end
                    if (is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                        errors++;
                    end
                end
            end
            // word decode, byte offsets within the word ignored
            if (psel && penable && pwrite && pready &&
                paddr[bss_pkg::PADDR_W-1:2] ==
                bss_pkg::ADDR_CAPACITY[bss_pkg::PADDR_W-1:2])
                cap_reg = pwdata[bss_pkg::CAP_W-1:0];
            if (item_valid && item_ready)
                expected_results.push_back(apply_op(operation, value));
            pending = expected_results.size();
        end
    end

endmodule

[tb/tb_byte_stack_with_search.sv]
// tb_byte_stack_with_search: drives stack operations and capacity writes into
// byte_stack_with_search; stack_result_checker judges the results. Depends on bss_pkg.
`timescale 1ns / 1ps

module tb_byte_stack_with_search;

    localparam int DEPTH       = bss_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    // operation code the block does not use; must leave the stack untouched
    localparam logic [bss_pkg::OP_W-1:0] OP_NOP = 2'd3;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bss_pkg::PADDR_W-1:0]  paddr;
    logic [bss_pkg::PDATA_W-1:0]  pwdata;
    logic [bss_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    logic                         item_valid;
    logic                         item_ready;
    logic [bss_pkg::OP_W-1:0]     operation;
    logic [bss_pkg::VALUE_W-1:0]  value;
    logic                         result_valid;
    logic                         result_ready;
    logic [bss_pkg::STATUS_W-1:0] status;
    logic [bss_pkg::FIDX_W-1:0]   found_index;
    logic [bss_pkg::VALUE_W-1:0]  top_value;
    logic [bss_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;

    int check_errors;
    int pending;
    int cycle_cnt = 0;
    // quiet: no idle cycles on either side for the current phase
    bit quiet;
    // hold_off: one long receiver stall requested by the stimulus process
    int hold_off;

    byte_stack_with_search #(.DEPTH(DEPTH)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .found_index  (found_index),
        .top_value    (top_value),
        .count        (count),
        .is_empty     (is_empty)
    );

    stack_result_checker #(.DEPTH(DEPTH)) u_stack_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .found_index  (found_index),
        .top_value    (top_value),
        .count        (count),
        .is_empty     (is_empty),
        .errors       (check_errors),
        .pending      (pending)
    );

    always
        #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side. Each result gets a fresh random stall, or none when quiet; the first
    // hold_off request replaces it with one long stall so the block backs up.
    initial
    begin : receiver
        int gap;
        bit held;
        held         = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (hold_off > 0 && !held)
            begin
                gap  = hold_off;
                held = 1'b1;
            end
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (result_valid)
                    break;
            end
        end
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    // Valid stays up across back-to-back items; it only drops for a gap.
    task automatic send_item(input logic [bss_pkg::OP_W-1:0] op,
                             input logic [bss_pkg::VALUE_W-1:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        value      <= val;
        forever
        begin
            @(posedge clk);
            if (item_ready)
                break;
        end
    endtask

    // Stops offering, waits for every outstanding result, then a short margin.
    // Every item yields a result, so once the queue is empty the block is idle.
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; register loads at the edge
    // that sees psel, penable, pwrite and pready together.
    task automatic write_capacity(input logic [bss_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= bss_pkg::ADDR_CAPACITY;
        pwdata  <= {{(bss_pkg::PDATA_W-bss_pkg::CAP_W){1'b0}}, cap};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Half the values come from a tiny alphabet so searches hit stored bytes;
    // the rest span the full byte so every bit toggles.
    function automatic logic [bss_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return bss_pkg::VALUE_W'($urandom_range(0, 3));
        return bss_pkg::VALUE_W'($urandom_range(0, 255));
    endfunction

    // Random mix: push_pct percent pushes, the rest split between pop and
    // search with an occasional unused code.
    task automatic run_random(input int n_items, input int push_pct);
        logic [bss_pkg::OP_W-1:0] op;
        int                       roll;
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                op = bss_pkg::OP_PUSH;
            else
            begin
                roll = $urandom_range(0, 19);
                if (roll < 9)
                    op = bss_pkg::OP_POP;
                else if (roll < 18)
                    op = bss_pkg::OP_SEARCH;
                else
                    op = OP_NOP;
            end
            send_item(op, pick_value());
        end
    endtask

    // New phase: drain, write the capacity, pick the idling style.
    task automatic new_phase(input logic [bss_pkg::CAP_W-1:0] cap, input bit no_gaps);
        settle();
        write_capacity(cap);
        quiet = no_gaps;
    endtask

    initial
    begin : stimulus
        // every block input known from time zero
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        item_valid = 1'b0;
        operation  = bss_pkg::OP_PUSH;
        value      = '0;
        quiet      = 1'b0;
        hold_off   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, capacity at its reset value, stack empty:
        // pop and search on empty, unused code, duplicates (lowest index
        // wins), a miss, byte extremes, then pop back down past empty.
        send_item(bss_pkg::OP_POP,    8'h00);
        send_item(bss_pkg::OP_SEARCH, 8'h00);
        send_item(OP_NOP,             8'hFF);
        send_item(bss_pkg::OP_PUSH,   8'h00);
        send_item(bss_pkg::OP_PUSH,   8'hFF);
        send_item(bss_pkg::OP_PUSH,   8'hA5);
        send_item(bss_pkg::OP_PUSH,   8'hFF);
        send_item(bss_pkg::OP_SEARCH, 8'hFF);
        send_item(bss_pkg::OP_SEARCH, 8'h00);
        send_item(bss_pkg::OP_SEARCH, 8'hA5);
        send_item(bss_pkg::OP_SEARCH, 8'h5A);
        send_item(OP_NOP,             8'h3C);
        send_item(bss_pkg::OP_POP,    8'h00);
        send_item(bss_pkg::OP_POP,    8'h00);
        send_item(bss_pkg::OP_SEARCH, 8'hFF);
        send_item(bss_pkg::OP_POP,    8'h00);
        send_item(bss_pkg::OP_POP,    8'h00);
        send_item(bss_pkg::OP_POP,    8'h00);

        // capacity zero: every push is refused
        new_phase(7'd0, 1'b0);
        run_random(8, 50);

        // smallest useful capacity, back to back
        new_phase(7'd1, 1'b1);
        run_random(30, 50);

        // capacity above the array size: limit is DEPTH; push-heavy to fill it
        new_phase(7'd127, 1'b0);
        run_random(110, 75);

        // capacity dropped under the stored count: pushes refused, pops still work
        new_phase(7'd5, 1'b0);
        run_random(40, 30);

        new_phase(7'd65, 1'b0);
        run_random(80, 60);

        // full-size capacity with one long receiver stall while items keep coming
        new_phase(7'd64, 1'b0);
        hold_off = 300;
        run_random(80, 50);

        for (int p = 0; p < 3; p++)
        begin
            new_phase(bss_pkg::CAP_W'($urandom_range(1, 64)), $urandom_range(0, 3) == 0);
            run_random(35, 50);
        end

        // drain, then allow the slowest search to finish
        settle();
        repeat (DEPTH + 8) @(negedge clk);
        if (check_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
